>>> hw/rtl/bcpe_pkg.sv
package bcpe_pkg;

   localparam int DEF_MAX_POINTS  = 8;
   localparam int DEF_COORD_BITS  = 16;
   localparam int DEF_T_FRAC_BITS = 16;

   localparam int DIGIT_BITS    = 16;
   localparam int BINOM_BITS    = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 17;
   localparam int COUNT_BITS    = 4;
   localparam int STEP_BITS     = 17;
   localparam int SAMPLE_BITS   = 16;
   localparam int PIDX_BITS     = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_SIZE   = 2'd1;

   localparam logic [COUNT_BITS-1:0] POINT_COUNT_RESET = 4'd4;
   localparam logic [STEP_BITS-1:0]  STEP_SIZE_RESET   = 17'd66;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_EVAL  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_ROUND,
      ST_EMIT
   } bcpe_state_type;

   typedef struct packed {
      logic start;
      logic pass_start;
      logic digit;
      logic round;
   } lane_ctrl_type;

   // Binomial coefficient by Pascal's triangle, for constant arguments only.
   function automatic int binomial(input int n, input int k);
      int row [0:31];
      int r;
      int c;
      for (c = 0; c < 32; c++) begin
         row[c] = 0;
      end
      row[0] = 1;
      for (r = 1; r <= n; r++) begin
         for (c = 31; c > 0; c--) begin
            row[c] = row[c] + row[c-1];
         end
      end
      return row[k];
   endfunction

endpackage

>>> hw/rtl/bcpe_lane.sv
module bcpe_lane #(
   parameter int COORD_BITS  = bcpe_pkg::DEF_COORD_BITS,
   parameter int T_FRAC_BITS = bcpe_pkg::DEF_T_FRAC_BITS,
   parameter int ACC_BITS    = 128,
   parameter int WP_BITS     = 33,
   parameter int SH_BITS     = 8
) (
   input  logic                          clock,
   input  bcpe_pkg::lane_ctrl_type       ctrl,
   input  logic [T_FRAC_BITS:0]          a_factor,
   input  logic [bcpe_pkg::DIGIT_BITS-1:0] b_digit,
   input  logic signed [WP_BITS-1:0]     weighted_point,
   input  logic [SH_BITS-1:0]            shift_amount,
   output logic signed [COORD_BITS-1:0]  coord
);
   import bcpe_pkg::*;

   localparam int SUM_BITS = WP_BITS + DIGIT_BITS + T_FRAC_BITS + 3;

   logic [ACC_BITS-1:0]        horner_ff;
   logic [ACC_BITS-1:0]        rounded_ff;
   logic signed [SUM_BITS-1:0] carry_ff;
   logic signed [SUM_BITS-1:0] prod_a;
   logic signed [SUM_BITS-1:0] prod_w;
   logic signed [SUM_BITS-1:0] digit_sum;

   // One digit of h*a + wp*b^i per cycle while ctrl.digit is high, modulo 2^ACC_BITS.
   always_comb begin
      prod_a    = signed'(SUM_BITS'(horner_ff[DIGIT_BITS-1:0]) * SUM_BITS'(a_factor));
      prod_w    = SUM_BITS'(weighted_point) * signed'(SUM_BITS'(b_digit));
      digit_sum = prod_a + prod_w + carry_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         horner_ff <= '0;
      end else if (ctrl.digit) begin
         horner_ff <= {digit_sum[DIGIT_BITS-1:0], horner_ff[ACC_BITS-1:DIGIT_BITS]};
      end
      if (ctrl.pass_start) begin
         carry_ff <= '0;
      end else if (ctrl.digit) begin
         carry_ff <= digit_sum >>> DIGIT_BITS;
      end
      if (ctrl.round) begin
         rounded_ff <= horner_ff + (ACC_BITS'(1) << (shift_amount - SH_BITS'(1)));
      end
   end

   assign coord = COORD_BITS'(rounded_ff >> shift_amount);

endmodule

>>> hw/rtl/bezier_curve_point_evaluator.sv
// Bezier curve point evaluator. A write beat (mode 0) stores one control point when its index
// is below the number of points in use, and leaves busy low, so further beats may follow at
// once. An evaluate beat (mode 1) raises busy and walks the control points in order: each
// point takes a memory read and one pass over all ND digits of the digit-serial Horner
// accumulator, where ND is the accumulator width in 16-bit digits (9 at the default
// parameters). When t lies past one, the passes are skipped and a past-end result with zero
// coordinates is emitted. The result appears on the rsp_ ports for one cycle with rsp_strobe
// high; it cannot be held off, and busy is already low in that cycle.
module bezier_curve_point_evaluator #(
   parameter int MAX_POINTS  = bcpe_pkg::DEF_MAX_POINTS,
   parameter int COORD_BITS  = bcpe_pkg::DEF_COORD_BITS,
   parameter int T_FRAC_BITS = bcpe_pkg::DEF_T_FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_mode,
   input  logic [bcpe_pkg::PIDX_BITS-1:0]         req_point_index,
   input  logic signed [COORD_BITS-1:0]           req_point_x,
   input  logic signed [COORD_BITS-1:0]           req_point_y,
   input  logic [bcpe_pkg::SAMPLE_BITS-1:0]       req_sample_index,
   output logic                                   rsp_strobe,
   output logic signed [COORD_BITS-1:0]           rsp_curve_x,
   output logic signed [COORD_BITS-1:0]           rsp_curve_y,
   output logic                                   rsp_past_end,
   input  logic                                   csr_write_en,
   input  logic [bcpe_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [bcpe_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import bcpe_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_POINTS);
   localparam int RAW_BITS = (MAX_POINTS - 1) * T_FRAC_BITS + COORD_BITS;
   localparam int NUM_DIGITS = (RAW_BITS + DIGIT_BITS - 1) / DIGIT_BITS + 1;
   localparam int ACC_BITS = NUM_DIGITS * DIGIT_BITS;
   localparam int DCNT_BITS = $clog2(NUM_DIGITS + 1);
   localparam int SH_BITS = $clog2(ACC_BITS + 1);
   localparam int WP_BITS = COORD_BITS + BINOM_BITS + 1;
   localparam int TN_BITS = SAMPLE_BITS + STEP_BITS;
   localparam int BSUM_BITS = DIGIT_BITS + T_FRAC_BITS + 2;
   localparam int ACT_BITS = COUNT_BITS + 1;

   bcpe_state_type state_ff, state_in;
   lane_ctrl_type  ctrl;

   logic [COUNT_BITS-1:0] point_count_ff;
   logic [STEP_BITS-1:0]  step_size_ff;

   logic signed [COORD_BITS-1:0] x_mem [MAX_POINTS];
   logic signed [COORD_BITS-1:0] y_mem [MAX_POINTS];
   logic [MAX_POINTS-1:0]        point_valid_ff;
   logic signed [COORD_BITS-1:0] rd_x_ff;
   logic signed [COORD_BITS-1:0] rd_y_ff;

   logic [BINOM_BITS-1:0] binom_rom [MAX_POINTS][MAX_POINTS];

   logic [ACT_BITS-1:0]  active_pts;
   logic [IDX_BITS-1:0]  n_pts;
   logic [IDX_BITS-1:0]  point_ff, point_in;
   logic [DCNT_BITS-1:0] digit_ff, digit_in;
   logic [TN_BITS-1:0]   tn_ff;
   logic                 past;
   logic                 past_ff, past_in;
   logic                 emit;
   logic                 write_hit;
   logic [IDX_BITS-1:0]  wr_addr;

   logic [T_FRAC_BITS:0]        a_factor;
   logic [T_FRAC_BITS:0]        b_factor;
   logic [ACC_BITS-1:0]         bpow_ff;
   logic [BSUM_BITS-1:0]        bcarry_ff;
   logic [BSUM_BITS-1:0]        bsum;
   logic [SH_BITS-1:0]          shift_amount;
   logic signed [WP_BITS-1:0]   wp_x_ff;
   logic signed [WP_BITS-1:0]   wp_y_ff;
   logic [BINOM_BITS-1:0]       weight;
   logic signed [COORD_BITS-1:0] lane_x;
   logic signed [COORD_BITS-1:0] lane_y;

   logic                         rsp_strobe_ff;
   logic signed [COORD_BITS-1:0] rsp_curve_x_ff;
   logic signed [COORD_BITS-1:0] rsp_curve_y_ff;
   logic                         rsp_past_end_ff;

   always_comb begin
      for (int r = 0; r < MAX_POINTS; r++) begin
         for (int c = 0; c < MAX_POINTS; c++) begin
            binom_rom[r][c] = BINOM_BITS'(binomial(r, c));
         end
      end
   end

   always_comb begin
      if (point_count_ff < COUNT_BITS'(2)) begin
         active_pts = ACT_BITS'(2);
      end else if (ACT_BITS'(point_count_ff) > ACT_BITS'(MAX_POINTS)) begin
         active_pts = ACT_BITS'(MAX_POINTS);
      end else begin
         active_pts = ACT_BITS'(point_count_ff);
      end
      n_pts = IDX_BITS'(active_pts - ACT_BITS'(1));
   end

   assign busy      = (state_ff != ST_IDLE);
   assign write_hit = start && !busy && (req_mode == MODE_WRITE)
                      && (ACT_BITS'(req_point_index) < active_pts);
   assign wr_addr   = IDX_BITS'(req_point_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= POINT_COUNT_RESET;
         step_size_ff   <= STEP_SIZE_RESET;
      end else if (csr_write_en) begin
         if (csr_index == CSR_POINT_COUNT) begin
            point_count_ff <= COUNT_BITS'(csr_wdata);
         end else if (csr_index == CSR_STEP_SIZE) begin
            step_size_ff <= STEP_BITS'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_valid_ff <= '0;
      end else if (write_hit) begin
         point_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (write_hit) begin
         x_mem[wr_addr] <= req_point_x;
         y_mem[wr_addr] <= req_point_y;
      end
      rd_x_ff <= point_valid_ff[point_in] ? x_mem[point_in] : '0;
      rd_y_ff <= point_valid_ff[point_in] ? y_mem[point_in] : '0;
   end

   assign past     = tn_ff > (TN_BITS'(1) << T_FRAC_BITS);
   assign a_factor = (T_FRAC_BITS + 1)'((TN_BITS'(1) << T_FRAC_BITS) - tn_ff);
   assign b_factor = (T_FRAC_BITS + 1)'(tn_ff);
   assign weight   = binom_rom[n_pts][point_ff];
   assign shift_amount = SH_BITS'(n_pts) * SH_BITS'(T_FRAC_BITS);
   assign bsum = BSUM_BITS'(bpow_ff[DIGIT_BITS-1:0]) * BSUM_BITS'(b_factor) + bcarry_ff;

   always_comb begin
      state_in = state_ff;
      point_in = point_ff;
      digit_in = digit_ff;
      past_in  = past_ff;
      ctrl     = '0;
      emit     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (req_mode == MODE_EVAL)) begin
               ctrl.start = 1'b1;
               point_in   = '0;
               past_in    = 1'b0;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (past) begin
               past_in  = 1'b1;
               state_in = ST_EMIT;
            end else begin
               ctrl.pass_start = 1'b1;
               digit_in        = '0;
               state_in        = ST_RUN;
            end
         end
         ST_RUN: begin
            ctrl.digit = 1'b1;
            digit_in   = digit_ff + DCNT_BITS'(1);
            if (digit_ff == DCNT_BITS'(NUM_DIGITS - 1)) begin
               if (point_ff == n_pts) begin
                  state_in = ST_ROUND;
               end else begin
                  point_in = point_ff + IDX_BITS'(1);
                  state_in = ST_LOAD;
               end
            end
         end
         ST_ROUND: begin
            ctrl.round = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            emit     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
      digit_ff <= digit_in;
      past_ff  <= past_in;
      if (ctrl.start) begin
         tn_ff     <= TN_BITS'(req_sample_index) * TN_BITS'(step_size_ff);
         bpow_ff   <= ACC_BITS'(1);
      end else if (ctrl.digit) begin
         bpow_ff   <= {bsum[DIGIT_BITS-1:0], bpow_ff[ACC_BITS-1:DIGIT_BITS]};
      end
      if (ctrl.pass_start) begin
         bcarry_ff <= '0;
         wp_x_ff   <= WP_BITS'(signed'({1'b0, weight})) * WP_BITS'(rd_x_ff);
         wp_y_ff   <= WP_BITS'(signed'({1'b0, weight})) * WP_BITS'(rd_y_ff);
      end else if (ctrl.digit) begin
         bcarry_ff <= bsum >> DIGIT_BITS;
      end
      if (emit) begin
         rsp_curve_x_ff  <= past_ff ? '0 : lane_x;
         rsp_curve_y_ff  <= past_ff ? '0 : lane_y;
         rsp_past_end_ff <= past_ff;
      end
   end

   bcpe_lane #(
      .COORD_BITS  (COORD_BITS),
      .T_FRAC_BITS (T_FRAC_BITS),
      .ACC_BITS    (ACC_BITS),
      .WP_BITS     (WP_BITS),
      .SH_BITS     (SH_BITS)
   ) u_lane_x (
      .clock          (clock),
      .ctrl           (ctrl),
      .a_factor       (a_factor),
      .b_digit        (bpow_ff[DIGIT_BITS-1:0]),
      .weighted_point (wp_x_ff),
      .shift_amount   (shift_amount),
      .coord          (lane_x)
   );

   bcpe_lane #(
      .COORD_BITS  (COORD_BITS),
      .T_FRAC_BITS (T_FRAC_BITS),
      .ACC_BITS    (ACC_BITS),
      .WP_BITS     (WP_BITS),
      .SH_BITS     (SH_BITS)
   ) u_lane_y (
      .clock          (clock),
      .ctrl           (ctrl),
      .a_factor       (a_factor),
      .b_digit        (bpow_ff[DIGIT_BITS-1:0]),
      .weighted_point (wp_y_ff),
      .shift_amount   (shift_amount),
      .coord          (lane_y)
   );

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_curve_x  = rsp_curve_x_ff;
   assign rsp_curve_y  = rsp_curve_y_ff;
   assign rsp_past_end = rsp_past_end_ff;

endmodule

>>> hw/rtl/bcpe_checker.sv
module bcpe_checker #(
   parameter int COORD_BITS = bcpe_pkg::DEF_COORD_BITS
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_mode,
   input logic                         rsp_strobe,
   input logic signed [COORD_BITS-1:0] rsp_curve_x,
   input logic signed [COORD_BITS-1:0] rsp_curve_y,
   input logic                         rsp_past_end
);
   import bcpe_pkg::*;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat shown while busy");

   a_past_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_past_end) |-> (rsp_curve_x == '0 && rsp_curve_y == '0))
      else $error("past-end result with non-zero coordinates");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_EVAL) |=> busy)
      else $error("evaluate beat did not raise busy");

   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_WRITE) |=> (!busy && !rsp_strobe))
      else $error("write beat caused work or a result");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

endmodule

bind bezier_curve_point_evaluator bcpe_checker #(.COORD_BITS(COORD_BITS)) u_bcpe_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_mode     (req_mode),
   .rsp_strobe   (rsp_strobe),
   .rsp_curve_x  (rsp_curve_x),
   .rsp_curve_y  (rsp_curve_y),
   .rsp_past_end (rsp_past_end)
);

>>> sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bcpe_pkg::*;

   localparam int NPTS = DEF_MAX_POINTS;
   localparam int CB   = DEF_COORD_BITS;
   localparam int TFB  = DEF_T_FRAC_BITS;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_B = 2'd3;

   typedef struct {
      logic signed [CB-1:0] cx;
      logic signed [CB-1:0] cy;
      logic                 past;
   } curve_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_mode = MODE_WRITE;
   logic [PIDX_BITS-1:0] req_point_index = '0;
   logic signed [CB-1:0] req_point_x = '0;
   logic signed [CB-1:0] req_point_y = '0;
   logic [SAMPLE_BITS-1:0] req_sample_index = '0;
   logic rsp_strobe;
   logic signed [CB-1:0] rsp_curve_x;
   logic signed [CB-1:0] rsp_curve_y;
   logic rsp_past_end;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   bezier_curve_point_evaluator dut (.*);

   // Local copy of the block's state.
   logic [COUNT_BITS-1:0] count_reg;
   logic [STEP_BITS-1:0]  step_reg;
   logic signed [CB-1:0]  ctrl_x [NPTS];
   logic signed [CB-1:0]  ctrl_y [NPTS];
   curve_point_type expected_points [$];
   int  mismatches = 0;
   bit  burst_mode = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic int active_points();
      if (count_reg < 2) return 2;
      if (count_reg > NPTS) return NPTS;
      return count_reg;
   endfunction

   function automatic longint choose(int n, int k);
      longint c = 1;
      for (int j = 1; j <= k; j++) c = c * (n - k + j) / j;
      return c;
   endfunction

   // Exact Bernstein sum, rounded half up, reduced to the coordinate width.
   function automatic logic [CB-1:0] bernstein(input logic signed [CB-1:0] pts [NPTS],
                                               input longint tn);
      logic signed [191:0] acc;
      logic signed [191:0] term;
      logic signed [191:0] a_w;
      logic signed [191:0] b_w;
      int n;
      n = active_points() - 1;
      a_w = (longint'(1) << TFB) - tn;
      b_w = tn;
      acc = '0;
      for (int i = 0; i <= n; i++) begin
         term = 192'(pts[i]) * 192'(choose(n, i));
         for (int j = 0; j < n - i; j++) term = term * a_w;
         for (int j = 0; j < i; j++) term = term * b_w;
         acc = acc + term;
      end
      acc = acc + (192'sd1 <<< (n * TFB - 1));
      acc = acc >>> (n * TFB);
      return acc[CB-1:0];
   endfunction

   function automatic void predict_beat(logic mode, logic [PIDX_BITS-1:0] idx,
                                        logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                                        logic [SAMPLE_BITS-1:0] k);
      curve_point_type p;
      longint tn;
      if (mode == MODE_WRITE) begin
         if (idx < active_points()) begin
            ctrl_x[idx] = px;
            ctrl_y[idx] = py;
         end
         return;
      end
      tn = longint'(k) * longint'(step_reg);
      if (tn > (longint'(1) << TFB)) begin
         p.cx = '0;
         p.cy = '0;
         p.past = 1'b1;
      end else begin
         p.cx = bernstein(ctrl_x, tn);
         p.cy = bernstein(ctrl_y, tn);
         p.past = 1'b0;
      end
      expected_points.insert(expected_points.size(), p);
   endfunction

   always @(posedge clock) begin
      if (rsp_strobe) begin
         if (expected_points.size() == 0) begin
            $error("unexpected beat: curve_x %0d curve_y %0d", rsp_curve_x, rsp_curve_y);
            mismatches++;
         end else begin
            curve_point_type e;
            e = expected_points.pop_front();
            if (rsp_curve_x !== e.cx) begin
               $error("curve_x: expected %0d, actual %0d", e.cx, rsp_curve_x);
               mismatches++;
            end
            if (rsp_curve_y !== e.cy) begin
               $error("curve_y: expected %0d, actual %0d", e.cy, rsp_curve_y);
               mismatches++;
            end
            if (rsp_past_end !== e.past) begin
               $error("past_end: expected %0d, actual %0d", e.past, rsp_past_end);
               mismatches++;
            end
         end
      end
   end

   task automatic send_beat(logic mode, logic [PIDX_BITS-1:0] idx,
                            logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                            logic [SAMPLE_BITS-1:0] k);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_point_index <= idx;
      req_point_x <= px;
      req_point_y <= py;
      req_sample_index <= k;
      do @(posedge clock); while (busy);
      predict_beat(mode, idx, px, py, k);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, int val);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(val);
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_POINT_COUNT) count_reg = COUNT_BITS'(val);
      else if (idx == CSR_STEP_SIZE) step_reg = STEP_BITS'(val);
   endtask

   task automatic send_point(int i, logic signed [CB-1:0] x, logic signed [CB-1:0] y);
      send_beat(MODE_WRITE, PIDX_BITS'(i), x, y, '0);
   endtask

   task automatic send_sample(int k);
      send_beat(MODE_EVAL, '0, CB'($urandom), CB'($urandom), SAMPLE_BITS'(k));
   endtask

   task automatic test_reset_defaults();
      send_sample(0);
      send_sample(992);
      send_sample(993);
      wait_idle();
   endtask

   task automatic test_point_extremes();
      write_csr(CSR_POINT_COUNT, 8);
      write_csr(CSR_STEP_SIZE, 65536);
      for (int i = 0; i < NPTS; i++)
         send_point(i, (i % 2) ? 16'sh7fff : 16'sh8000, (i % 2) ? 16'sh8000 : 16'sh7fff);
      send_sample(0);
      send_sample(1);
      send_sample(2);
      send_sample(16'hffff);
      write_csr(CSR_STEP_SIZE, 32768);
      send_sample(1);
      wait_idle();
      write_csr(CSR_POINT_COUNT, 3);
      send_point(5, 16'sh1234, 16'sh4321);
      send_point(3, 16'sh1111, 16'sh2222);
      send_point(2, 16'sh7fff, 16'sh7fff);
      send_sample(1);
      wait_idle();
   endtask

   task automatic test_config_corners();
      write_csr(CSR_STEP_SIZE, 0);
      send_sample(16'hffff);
      wait_idle();
      write_csr(CSR_STEP_SIZE, 17'h1ffff);
      send_sample(0);
      send_sample(1);
      wait_idle();
      write_csr(CSR_POINT_COUNT, 0);
      send_point(2, 16'sh0100, 16'sh0100);
      write_csr(CSR_STEP_SIZE, 20000);
      send_sample(2);
      wait_idle();
      write_csr(CSR_POINT_COUNT, 15);
      send_point(7, 16'sh0f0f, 16'shf0f0);
      send_sample(3);
      wait_idle();
      write_csr(CSR_SPARE_A, 17'h1ffff);
      write_csr(CSR_SPARE_B, 17'h00005);
      send_sample(1);
      wait_idle();
   endtask

   task automatic test_random_curves();
      int counts [] = '{2, 3, 4, 5, 6, 7, 8, 1, 9, 0, 15};
      int lim;
      logic signed [CB-1:0] v;
      for (int ph = 0; ph < 11; ph++) begin
         write_csr(CSR_POINT_COUNT, counts[ph]);
         case (ph % 5)
            0: write_csr(CSR_STEP_SIZE, 1);
            1: write_csr(CSR_STEP_SIZE, 65536);
            2: write_csr(CSR_STEP_SIZE, 0);
            default: write_csr(CSR_STEP_SIZE, $urandom_range(1, 4096));
         endcase
         lim = (step_reg == 0) ? 65535 : 65536 / step_reg;
         if (lim > 65535) lim = 65535;
         for (int it = 0; it < 120; it++) begin
            if (it % 30 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 3) == 0) begin
               v = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000)
                                              : CB'($urandom);
               send_point($urandom_range(0, 7), v, CB'($urandom));
            end else if ($urandom_range(0, 9) == 0) begin
               send_sample(int'($urandom_range(0, 65535)));
            end else begin
               send_sample(int'($urandom_range(0, lim)));
            end
         end
         burst_mode = 0;
         wait_idle();
      end
   endtask

   initial begin
      count_reg = POINT_COUNT_RESET;
      step_reg = STEP_SIZE_RESET;
      for (int i = 0; i < NPTS; i++) begin
         ctrl_x[i] = '0;
         ctrl_y[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_point_extremes();
      test_config_corners();
      test_random_curves();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
